// File: src/wbgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and fixed-point helpers for the wrench compensation filter.
package wbgc_pkg;

  // Calibration length; a power of two, so the averaging divide is a shift
  localparam int CALIB_SAMPLES = 64;
  localparam int CNT_W         = $clog2(CALIB_SAMPLES + 1);
  localparam int AXES          = 6;
  localparam int ACC_W         = 66;
  localparam int OPD_W         = 33;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_WEIGHT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_OFFSET_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_OFFSET_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_OFFSET_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN   = 3'd4;

  // Register values after reset
  localparam logic [30:0]        RST_LOAD_WEIGHT   = 31'd64269;
  localparam logic signed [31:0] RST_LOAD_OFFSET_X = 32'sd0;
  localparam logic signed [31:0] RST_LOAD_OFFSET_Y = 32'sd0;
  localparam logic signed [31:0] RST_LOAD_OFFSET_Z = 32'sd2294;
  localparam logic [16:0]        RST_FILTER_GAIN   = 17'd58982;

  // Unity gain in Q1.16
  localparam logic [16:0] GAIN_ONE = 17'h10000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MODEL,
    ST_TORQ,
    ST_CALIB,
    ST_BIAS,
    ST_FILT,
    ST_DONE
  } state_t;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    state_t      st;
    logic [2:0]  idx;
    logic [1:0]  ph;
    logic        cap;
    logic        load_out;
  } ctrl_t;

  typedef struct packed {
    logic                    en;
    logic                    clr;
    logic                    sub;
    logic signed [OPD_W-1:0] a;
    logic signed [OPD_W-1:0] b;
  } mac_op_t;

  localparam acc_t S32_HI = (acc_t'(1) <<< 31) - acc_t'(1);
  localparam acc_t S32_LO = -(acc_t'(1) <<< 31);
  localparam acc_t S40_HI = (acc_t'(1) <<< 39) - acc_t'(1);
  localparam acc_t S40_LO = -(acc_t'(1) <<< 39);

  // Round half up, then shift right by k (k at least one)
  function automatic acc_t round_shr(input acc_t x, input int unsigned k);
    acc_t t;
    t = x + (acc_t'(1) <<< (k - 1));
    return t >>> k;
  endfunction

  function automatic logic signed [31:0] sat32(input acc_t x);
    if (x > S32_HI) return S32_HI[31:0];
    else if (x < S32_LO) return S32_LO[31:0];
    else return x[31:0];
  endfunction

  function automatic logic signed [39:0] sat40(input acc_t x);
    if (x > S40_HI) return S40_HI[39:0];
    else if (x < S40_LO) return S40_LO[39:0];
    else return x[39:0];
  endfunction

endpackage
`default_nettype wire

// File: src/wbgc_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared signed multiply-accumulate unit used for every product of the filter.
module wbgc_mac (
  input  wire logic              clk,
  input  wire wbgc_pkg::mac_op_t op,
  output wbgc_pkg::acc_t         acc
);

  wbgc_pkg::acc_t acc_r;
  wbgc_pkg::acc_t acc_nxt;
  wbgc_pkg::acc_t prod;
  wbgc_pkg::acc_t base;

  // Multiply, then clear-or-keep and add or subtract
  always_comb begin
    prod    = op.a * op.b;
    base    = op.clr ? '0 : acc_r;
    acc_nxt = op.sub ? (base - prod) : (base + prod);
  end

  // Hold the sum between steps
  always_ff @(posedge clk) begin
    if (op.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

// File: src/wbgc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequencer: steps the shared multiply-accumulate unit through one sample.
module wbgc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_pose_valid,
  input  wire logic            out_busy,
  output logic                 in_stall,
  output wbgc_pkg::ctrl_t      ctrl,
  output logic                 calibrated
);

  wbgc_pkg::state_t state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [wbgc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic cal_r, cal_nxt;
  logic [1:0] last_ph;
  logic [2:0] last_idx;
  logic step_end;
  logic pass_end;

  // Steps per axis and axes per pass of each state
  always_comb begin
    last_ph  = 2'd0;
    last_idx = 3'd5;
    unique case (state_r)
      wbgc_pkg::ST_MODEL: begin
        last_ph  = 2'd1;
        last_idx = 3'd2;
      end
      wbgc_pkg::ST_TORQ: begin
        last_ph  = 2'd2;
        last_idx = 3'd2;
      end
      wbgc_pkg::ST_FILT: begin
        last_ph = 2'd2;
      end
      default: begin
      end
    endcase
  end

  assign step_end = (ph_r == last_ph);
  assign pass_end = step_end && (idx_r == last_idx);

  // Next state and counters
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ph_nxt    = ph_r;
    cnt_nxt   = cnt_r;
    cal_nxt   = cal_r;
    if (state_r != wbgc_pkg::ST_IDLE && state_r != wbgc_pkg::ST_DONE) begin
      if (step_end) begin
        ph_nxt  = 2'd0;
        idx_nxt = pass_end ? 3'd0 : (idx_r + 3'd1);
      end else begin
        ph_nxt = ph_r + 2'd1;
      end
    end
    unique case (state_r)
      wbgc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_pose_valid ? wbgc_pkg::ST_MODEL : wbgc_pkg::ST_DONE;
        end
      end
      wbgc_pkg::ST_MODEL: begin
        if (pass_end) state_nxt = wbgc_pkg::ST_TORQ;
      end
      wbgc_pkg::ST_TORQ: begin
        if (pass_end) state_nxt = cal_r ? wbgc_pkg::ST_FILT : wbgc_pkg::ST_CALIB;
      end
      wbgc_pkg::ST_CALIB: begin
        if (pass_end) begin
          cnt_nxt = cnt_r + wbgc_pkg::CNT_W'(1);
          if (cnt_r == wbgc_pkg::CNT_W'(wbgc_pkg::CALIB_SAMPLES - 1)) begin
            state_nxt = wbgc_pkg::ST_BIAS;
          end else begin
            state_nxt = wbgc_pkg::ST_DONE;
          end
        end
      end
      wbgc_pkg::ST_BIAS: begin
        if (pass_end) begin
          cal_nxt   = 1'b1;
          state_nxt = wbgc_pkg::ST_FILT;
        end
      end
      wbgc_pkg::ST_FILT: begin
        if (pass_end) state_nxt = wbgc_pkg::ST_DONE;
      end
      wbgc_pkg::ST_DONE: begin
        if (!out_busy) state_nxt = wbgc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = wbgc_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall      = (state_r != wbgc_pkg::ST_IDLE);
    ctrl.st       = state_r;
    ctrl.idx      = idx_r;
    ctrl.ph       = ph_r;
    ctrl.cap      = (state_r == wbgc_pkg::ST_IDLE) && in_valid;
    ctrl.load_out = (state_r == wbgc_pkg::ST_DONE) && !out_busy;
    calibrated    = cal_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wbgc_pkg::ST_IDLE;
      idx_r   <= 3'd0;
      ph_r    <= 2'd0;
      cnt_r   <= '0;
      cal_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ph_r    <= ph_nxt;
      cnt_r   <= cnt_nxt;
      cal_r   <= cal_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/wrench_bias_gravity_comp_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level: force/torque bias and gravity-load compensation with a low-pass filter.
//
// Takes one raw six-axis wrench word with the gravity direction and gives one
// filtered, compensated wrench word back. All products run through a single
// 33x33 multiply-accumulate unit, one step after another: load force (3
// products, each with a writeback), load torque (two products and a writeback
// per axis), calibration accumulation until the bias is ready, bias averaging
// on the last calibration word and, once the bias is ready, the filter (two
// products and a writeback per axis). The word is accepted first and handed
// to the output register last; with pose_valid low it goes straight there.
// The first 64 words with pose_valid high form the bias; outputs stay zero
// and bias_ready low until then. A finished word waits in the output register
// while the next one is accepted. The user must write the configuration port
// only while the block is idle; the block itself does not enforce this.
module wrench_bias_gravity_comp_filter (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [31:0]                  in_force_x,
  input  wire logic signed [31:0]                  in_force_y,
  input  wire logic signed [31:0]                  in_force_z,
  input  wire logic signed [31:0]                  in_torque_x,
  input  wire logic signed [31:0]                  in_torque_y,
  input  wire logic signed [31:0]                  in_torque_z,
  input  wire logic signed [15:0]                  in_down_dir_x,
  input  wire logic signed [15:0]                  in_down_dir_y,
  input  wire logic signed [15:0]                  in_down_dir_z,
  input  wire logic                                in_pose_valid,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [31:0]                       out_filt_force_x,
  output logic signed [31:0]                       out_filt_force_y,
  output logic signed [31:0]                       out_filt_force_z,
  output logic signed [31:0]                       out_filt_torque_x,
  output logic signed [31:0]                       out_filt_torque_y,
  output logic signed [31:0]                       out_filt_torque_z,
  output logic                                     out_bias_ready,
  input  wire logic                                cfg_we,
  input  wire logic [wbgc_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [wbgc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  wbgc_pkg::ctrl_t   ctrl;
  wbgc_pkg::mac_op_t mac_op;
  wbgc_pkg::acc_t    acc;
  logic              calibrated;
  logic              out_busy;

  // Configuration registers
  logic [30:0]        weight_r;
  logic signed [31:0] ofs_x_r;
  logic signed [31:0] ofs_y_r;
  logic signed [31:0] ofs_z_r;
  logic [16:0]        gain_r;

  // Sample and working registers
  logic signed [31:0] raw_r [wbgc_pkg::AXES];
  logic signed [15:0] dir_r [3];
  logic signed [31:0] lf_r [3];
  logic signed [31:0] lt_r [3];
  logic signed [39:0] bias_r [wbgc_pkg::AXES];
  logic signed [31:0] filt_r [wbgc_pkg::AXES];
  logic signed [31:0] comp_r;

  // Output register
  logic               out_valid_r;
  logic signed [31:0] out_filt_r [wbgc_pkg::AXES];
  logic               out_ready_r;

  // Per-axis datapath values
  logic signed [31:0] raw_sel;
  logic signed [31:0] mdl_sel;
  logic signed [39:0] bias_sel;
  logic signed [31:0] filt_sel;
  logic signed [33:0] term_w;
  logic signed [31:0] term32;
  logic signed [40:0] sum_w;
  logic signed [39:0] sum40;
  logic signed [33:0] comp_w;
  logic signed [31:0] comp_new;
  logic               bias_neg;
  logic signed [40:0] bias_ext;
  logic signed [40:0] mag_s;
  logic [40:0]        quot;
  logic signed [41:0] quot_s;
  logic signed [39:0] bias_new;
  logic signed [31:0] lf_new;
  logic signed [31:0] rnd16;
  logic [16:0]        g_eff;
  logic [16:0]        g_cmp;
  logic signed [32:0] trq_a;
  logic signed [32:0] trq_b;

  wbgc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_pose_valid (in_pose_valid),
    .out_busy      (out_busy),
    .in_stall      (in_stall),
    .ctrl          (ctrl),
    .calibrated    (calibrated)
  );

  wbgc_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .acc (acc)
  );

  assign out_busy = out_valid_r && out_stall;

  // Pick the axis under work
  always_comb begin
    raw_sel  = raw_r[ctrl.idx];
    bias_sel = bias_r[ctrl.idx];
    filt_sel = filt_r[ctrl.idx];
    if (ctrl.idx < 3'd3) begin
      mdl_sel = lf_r[ctrl.idx[1:0]];
    end else begin
      mdl_sel = lt_r[2'(ctrl.idx - 3'd3)];
    end
  end

  // Accumulate, average and compensate one axis
  always_comb begin
    term_w   = 34'(raw_sel) - 34'(mdl_sel);
    term32   = wbgc_pkg::sat32(wbgc_pkg::acc_t'(term_w));
    sum_w    = 41'(bias_sel) + 41'(term32);
    sum40    = wbgc_pkg::sat40(wbgc_pkg::acc_t'(sum_w));
    comp_w   = 34'(raw_sel) - 34'($signed(bias_sel[31:0])) - 34'(mdl_sel);
    comp_new = wbgc_pkg::sat32(wbgc_pkg::acc_t'(comp_w));
    bias_neg = bias_sel[39];
    bias_ext = 41'(bias_sel);
    mag_s    = bias_neg ? -bias_ext : bias_ext;
    quot     = ($unsigned(mag_s) + 41'(wbgc_pkg::CALIB_SAMPLES / 2))
               / 41'(wbgc_pkg::CALIB_SAMPLES);
    quot_s   = bias_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    bias_new = 40'(wbgc_pkg::sat32(wbgc_pkg::acc_t'(quot_s)));
  end

  // Round and saturate the accumulator
  always_comb begin
    lf_new = wbgc_pkg::sat32(-wbgc_pkg::round_shr(acc, 14));
    rnd16  = wbgc_pkg::sat32(wbgc_pkg::round_shr(acc, 16));
  end

  // Clamp the filter gain to one
  always_comb begin
    g_eff = (gain_r > wbgc_pkg::GAIN_ONE) ? wbgc_pkg::GAIN_ONE : gain_r;
    g_cmp = wbgc_pkg::GAIN_ONE - g_eff;
  end

  // Cross product terms: first product added, second subtracted
  always_comb begin
    case ({ctrl.idx[1:0], ctrl.ph[0]})
      3'b000: begin trq_a = 33'(ofs_y_r); trq_b = 33'(lf_r[2]); end
      3'b001: begin trq_a = 33'(ofs_z_r); trq_b = 33'(lf_r[1]); end
      3'b010: begin trq_a = 33'(ofs_z_r); trq_b = 33'(lf_r[0]); end
      3'b011: begin trq_a = 33'(ofs_x_r); trq_b = 33'(lf_r[2]); end
      3'b100: begin trq_a = 33'(ofs_x_r); trq_b = 33'(lf_r[1]); end
      3'b101: begin trq_a = 33'(ofs_y_r); trq_b = 33'(lf_r[0]); end
      default: begin trq_a = '0; trq_b = '0; end
    endcase
  end

  // Drive the shared multiply-accumulate unit
  always_comb begin
    mac_op = '0;
    unique case (ctrl.st)
      wbgc_pkg::ST_MODEL: begin
        if (ctrl.ph == 2'd0) begin
          mac_op.en  = 1'b1;
          mac_op.clr = 1'b1;
          mac_op.a   = $signed({2'b00, weight_r});
          mac_op.b   = 33'(dir_r[ctrl.idx[1:0]]);
        end
      end
      wbgc_pkg::ST_TORQ: begin
        if (ctrl.ph != 2'd2) begin
          mac_op.en  = 1'b1;
          mac_op.clr = (ctrl.ph == 2'd0);
          mac_op.sub = (ctrl.ph == 2'd1);
          mac_op.a   = trq_a;
          mac_op.b   = trq_b;
        end
      end
      wbgc_pkg::ST_FILT: begin
        if (ctrl.ph == 2'd0) begin
          mac_op.en  = 1'b1;
          mac_op.clr = 1'b1;
          mac_op.a   = $signed({16'd0, g_eff});
          mac_op.b   = 33'(filt_sel);
        end else if (ctrl.ph == 2'd1) begin
          mac_op.en = 1'b1;
          mac_op.a  = $signed({16'd0, g_cmp});
          mac_op.b  = 33'(comp_r);
        end
      end
      default: begin
      end
    endcase
  end

  // Capture the sample, write back load model terms, hold the output word
  always_ff @(posedge clk) begin
    if (ctrl.cap) begin
      raw_r[0] <= in_force_x;
      raw_r[1] <= in_force_y;
      raw_r[2] <= in_force_z;
      raw_r[3] <= in_torque_x;
      raw_r[4] <= in_torque_y;
      raw_r[5] <= in_torque_z;
      dir_r[0] <= in_down_dir_x;
      dir_r[1] <= in_down_dir_y;
      dir_r[2] <= in_down_dir_z;
    end
    if (ctrl.st == wbgc_pkg::ST_MODEL && ctrl.ph == 2'd1) begin
      lf_r[ctrl.idx[1:0]] <= lf_new;
    end
    if (ctrl.st == wbgc_pkg::ST_TORQ && ctrl.ph == 2'd2) begin
      lt_r[ctrl.idx[1:0]] <= rnd16;
    end
    if (ctrl.st == wbgc_pkg::ST_FILT && ctrl.ph == 2'd0) begin
      comp_r <= comp_new;
    end
    if (ctrl.load_out) begin
      for (int i = 0; i < wbgc_pkg::AXES; i++) begin
        out_filt_r[i] <= filt_r[i];
      end
      out_ready_r <= calibrated;
    end
  end

  // Configuration, bias, filter state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r    <= wbgc_pkg::RST_LOAD_WEIGHT;
      ofs_x_r     <= wbgc_pkg::RST_LOAD_OFFSET_X;
      ofs_y_r     <= wbgc_pkg::RST_LOAD_OFFSET_Y;
      ofs_z_r     <= wbgc_pkg::RST_LOAD_OFFSET_Z;
      gain_r      <= wbgc_pkg::RST_FILTER_GAIN;
      out_valid_r <= 1'b0;
      for (int i = 0; i < wbgc_pkg::AXES; i++) begin
        bias_r[i] <= '0;
        filt_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          wbgc_pkg::REG_LOAD_WEIGHT:   weight_r <= cfg_wdata[30:0];
          wbgc_pkg::REG_LOAD_OFFSET_X: ofs_x_r  <= $signed(cfg_wdata);
          wbgc_pkg::REG_LOAD_OFFSET_Y: ofs_y_r  <= $signed(cfg_wdata);
          wbgc_pkg::REG_LOAD_OFFSET_Z: ofs_z_r  <= $signed(cfg_wdata);
          wbgc_pkg::REG_FILTER_GAIN:   gain_r   <= cfg_wdata[16:0];
          default: begin
          end
        endcase
      end
      if (ctrl.st == wbgc_pkg::ST_CALIB) begin
        bias_r[ctrl.idx] <= sum40;
      end
      if (ctrl.st == wbgc_pkg::ST_BIAS) begin
        bias_r[ctrl.idx] <= bias_new;
      end
      if (ctrl.st == wbgc_pkg::ST_FILT && ctrl.ph == 2'd2) begin
        filt_r[ctrl.idx] <= rnd16;
      end
      if (ctrl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_filt_force_x  = out_filt_r[0];
  assign out_filt_force_y  = out_filt_r[1];
  assign out_filt_force_z  = out_filt_r[2];
  assign out_filt_torque_x = out_filt_r[3];
  assign out_filt_torque_y = out_filt_r[4];
  assign out_filt_torque_z = out_filt_r[5];
  assign out_bias_ready    = out_ready_r;

  // Calibration never undoes itself
  a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    calibrated |=> calibrated)
    else $error("calibration flag dropped");

  // Filter state stays zero until the bias is ready
  a_filt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !calibrated |-> (filt_r[0] == 32'sd0 && filt_r[1] == 32'sd0 && filt_r[2] == 32'sd0 &&
                     filt_r[3] == 32'sd0 && filt_r[4] == 32'sd0 && filt_r[5] == 32'sd0))
    else $error("filter state moved before calibration");

  // An accepted word starts the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (ctrl.st != wbgc_pkg::ST_IDLE))
    else $error("accepted word did not start the sequencer");

endmodule
`default_nettype wire
